@@ sv/ckb_pkg.sv @@
// Shared types and constants of the clipped color-key blitter.
// No dependencies; the front, back, top level and testbench import this package.
package ckb_pkg;

   // Configuration port
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLIP_LEFT     = 3'd0,
      CSR_CLIP_TOP      = 3'd1,
      CSR_CLIP_WIDTH    = 3'd2,
      CSR_CLIP_HEIGHT   = 3'd3,
      CSR_SOURCE_WIDTH  = 3'd4,
      CSR_SOURCE_HEIGHT = 3'd5,
      CSR_TARGET_WIDTH  = 3'd6
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] RST_CLIP_LEFT     = 12'd0;
   localparam logic [CSR_DATA_W-1:0] RST_CLIP_TOP      = 12'd0;
   localparam logic [CSR_DATA_W-1:0] RST_CLIP_WIDTH    = 12'd640;
   localparam logic [CSR_DATA_W-1:0] RST_CLIP_HEIGHT   = 12'd480;
   localparam logic [CSR_DATA_W-1:0] RST_SOURCE_WIDTH  = 12'd0;
   localparam logic [CSR_DATA_W-1:0] RST_SOURCE_HEIGHT = 12'd0;
   localparam logic [CSR_DATA_W-1:0] RST_TARGET_WIDTH  = 12'd640;

   // Defaults of the top-level parameters
   localparam int DEFAULT_MAX_DIM   = 2048;
   localparam int DEFAULT_ADDR_BITS = 22;

   // Field widths
   localparam int COORD_W = 16;
   localparam int PIXEL_W = 32;
   localparam int SPAN_W  = 12;
   // Signed width of the clamp arithmetic; covers 16-bit coordinates and sizes
   localparam int CALC_W  = 20;

   // Entries of the queue between front and back; also the credit limit
   localparam int Q_DEPTH = 8;

   // Pixel constants
   localparam logic [PIXEL_W-1:0] KEY_MASK     = 32'h0010_1010;
   localparam logic [PIXEL_W-1:0] RGB_MASK     = 32'h00FF_FFFF;
   localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   // Classification of one queued item
   typedef struct packed {
      logic is_start;
      logic empty;
      logic key_enable;
   } blit_ctl_type;

endpackage

@@ sv/clipped_colorkey_blitter_top.sv @@
// Clipped rectangle blitter with color key.
//
// Request channel (req_*): a start command (command 0) carries destination
// corner, source offset, size, color key and key enable; a pixel command
// (command 1) carries one source pixel of the clipped region in row order.
// Every request gives exactly one result on rsp_*: for a start the empty flag
// and the first source address, for a pixel its target address, the pixel
// with opaque alpha, the write enable and the last flag.
// Configuration (csr_*) takes a register index and 12-bit data; csr_ready is
// always high. Write registers only while no request is in flight.
// Path: the transfer loads the first of four front stages; clamping and
// address products pass through the other three, then the item goes through
// the queue into the result register.
// Throughput: one request per cycle while req_stall is low; the back stage
// updates the source and target pointers once per emitted pixel.
// Stalls: when rsp_stall holds, the result register holds and the queue
// fills; req_stall rises once 8 requests are in the front stages or queue.
// Reset clears in-flight requests, ends any blit and loads the register
// defaults; the block is ready in the next cycle.
module clipped_colorkey_blitter_top import ckb_pkg::*; #(
   parameter int MAX_DIM   = DEFAULT_MAX_DIM,
   parameter int ADDR_BITS = DEFAULT_ADDR_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_dest_x,
   input  logic signed [COORD_W-1:0] req_dest_y,
   input  logic signed [COORD_W-1:0] req_src_offset_x,
   input  logic signed [COORD_W-1:0] req_src_offset_y,
   input  logic        [COORD_W-1:0] req_rect_width,
   input  logic        [COORD_W-1:0] req_rect_height,
   input  logic        [PIXEL_W-1:0] req_key_color,
   input  logic                      req_key_enable,
   input  logic        [PIXEL_W-1:0] req_pixel_in,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_empty_res,
   output logic      [ADDR_BITS-1:0] rsp_next_src_addr,
   output logic      [ADDR_BITS-1:0] rsp_dest_addr,
   output logic        [PIXEL_W-1:0] rsp_pixel_out,
   output logic                      rsp_write_enable,
   output logic                      rsp_last,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic    [CSR_INDEX_W-1:0] csr_index,
   input  logic     [CSR_DATA_W-1:0] csr_data
);

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int ENTRY_W = $bits(blit_ctl_type) + 2 * SPAN_W + 2 * ADDR_BITS + PIXEL_W;
   localparam logic [CSR_DATA_W:0] DIM_LIMIT = (CSR_DATA_W + 1)'(MAX_DIM);

   logic [CSR_DATA_W-1:0] clip_left_ff, clip_top_ff, clip_width_ff, clip_height_ff;
   logic [CSR_DATA_W-1:0] source_width_ff, source_height_ff, target_width_ff;

   logic [DIM_W-1:0] cl_c, ct_c, cw_c, ch_c, sw_c, sh_c, tw_c;

   logic                 q_push;
   blit_ctl_type         push_ctl;
   logic [SPAN_W-1:0]    push_span, push_rows;
   logic [ADDR_BITS-1:0] push_src_addr, push_dst_addr;
   logic [PIXEL_W-1:0]   push_data;
   logic [ENTRY_W-1:0]   q_push_data, q_pop_data;
   logic                 q_pop, q_not_empty, q_full;
   blit_ctl_type         q_ctl;
   logic [SPAN_W-1:0]    q_span, q_rows;
   logic [ADDR_BITS-1:0] q_src_addr, q_dst_addr;
   logic [PIXEL_W-1:0]   q_data;

   // Saturate a register value at the largest dimension
   function automatic logic [DIM_W-1:0] clip_dim(input logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W:0] w;
      w = {1'b0, v};
      if (w > DIM_LIMIT) begin
         w = DIM_LIMIT;
      end
      return w[DIM_W-1:0];
   endfunction

   assign csr_ready = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff     <= RST_CLIP_LEFT;
         clip_top_ff      <= RST_CLIP_TOP;
         clip_width_ff    <= RST_CLIP_WIDTH;
         clip_height_ff   <= RST_CLIP_HEIGHT;
         source_width_ff  <= RST_SOURCE_WIDTH;
         source_height_ff <= RST_SOURCE_HEIGHT;
         target_width_ff  <= RST_TARGET_WIDTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:     clip_left_ff     <= csr_data;
            CSR_CLIP_TOP:      clip_top_ff      <= csr_data;
            CSR_CLIP_WIDTH:    clip_width_ff    <= csr_data;
            CSR_CLIP_HEIGHT:   clip_height_ff   <= csr_data;
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data;
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_data;
            CSR_TARGET_WIDTH:  target_width_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign cl_c = clip_dim(clip_left_ff);
   assign ct_c = clip_dim(clip_top_ff);
   assign cw_c = clip_dim(clip_width_ff);
   assign ch_c = clip_dim(clip_height_ff);
   assign sw_c = clip_dim(source_width_ff);
   assign sh_c = clip_dim(source_height_ff);
   assign tw_c = clip_dim(target_width_ff);

   ckb_front #(
      .MAX_DIM   (MAX_DIM),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .req_src_offset_x (req_src_offset_x),
      .req_src_offset_y (req_src_offset_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_key_color    (req_key_color),
      .req_key_enable   (req_key_enable),
      .req_pixel_in     (req_pixel_in),
      .clip_left        (cl_c),
      .clip_top         (ct_c),
      .clip_width       (cw_c),
      .clip_height      (ch_c),
      .source_width     (sw_c),
      .source_height    (sh_c),
      .target_width     (tw_c),
      .q_pop            (q_pop),
      .push_valid       (q_push),
      .push_ctl         (push_ctl),
      .push_span        (push_span),
      .push_rows        (push_rows),
      .push_src_addr    (push_src_addr),
      .push_dst_addr    (push_dst_addr),
      .push_data        (push_data)
   );

   // Pack and unpack queue entries
   assign q_push_data = {push_ctl, push_span, push_rows, push_src_addr, push_dst_addr,
                         push_data};
   assign {q_ctl, q_span, q_rows, q_src_addr, q_dst_addr, q_data} = q_pop_data;

   ckb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   ckb_back #(
      .MAX_DIM   (MAX_DIM),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_not_empty),
      .q_pop             (q_pop),
      .q_ctl             (q_ctl),
      .q_span            (q_span),
      .q_rows            (q_rows),
      .q_src_addr        (q_src_addr),
      .q_dst_addr        (q_dst_addr),
      .q_data            (q_data),
      .source_width      (sw_c),
      .target_width      (tw_c),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_empty_res     (rsp_empty_res),
      .rsp_next_src_addr (rsp_next_src_addr),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTH
   // Credits keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   // A full queue means every credit is taken
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> req_stall)
      else $error("requests taken while queue full");

   // Every pop lands in the result register
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("popped item lost before result");
`endif

endmodule

@@ sv/ckb_queue.sv @@
// Small register FIFO that decouples the blitter front from its back.
// Depends on nothing but its parameters.
module ckb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry being pushed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/ckb_front.sv @@
// Blitter front: accepts requests, clamps start commands to the source image
// and clip rectangle and forms the first source and target addresses.
// Depends on ckb_pkg.
module ckb_front import ckb_pkg::*; #(
   parameter int MAX_DIM   = DEFAULT_MAX_DIM,
   parameter int ADDR_BITS = DEFAULT_ADDR_BITS,
   localparam int DIM_W    = $clog2(MAX_DIM + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic signed [COORD_W-1:0]  req_dest_x,
   input  logic signed [COORD_W-1:0]  req_dest_y,
   input  logic signed [COORD_W-1:0]  req_src_offset_x,
   input  logic signed [COORD_W-1:0]  req_src_offset_y,
   input  logic        [COORD_W-1:0]  req_rect_width,
   input  logic        [COORD_W-1:0]  req_rect_height,
   input  logic        [PIXEL_W-1:0]  req_key_color,
   input  logic                       req_key_enable,
   input  logic        [PIXEL_W-1:0]  req_pixel_in,
   // clamped configuration
   input  logic        [DIM_W-1:0]    clip_left,
   input  logic        [DIM_W-1:0]    clip_top,
   input  logic        [DIM_W-1:0]    clip_width,
   input  logic        [DIM_W-1:0]    clip_height,
   input  logic        [DIM_W-1:0]    source_width,
   input  logic        [DIM_W-1:0]    source_height,
   input  logic        [DIM_W-1:0]    target_width,
   // queue side
   input  logic                       q_pop,
   output logic                       push_valid,
   output blit_ctl_type               push_ctl,
   output logic        [SPAN_W-1:0]   push_span,
   output logic        [SPAN_W-1:0]   push_rows,
   output logic        [ADDR_BITS-1:0] push_src_addr,
   output logic        [ADDR_BITS-1:0] push_dst_addr,
   output logic        [PIXEL_W-1:0]  push_data
);

   localparam int CRED_W = $clog2(Q_DEPTH + 1);
   localparam int PROD_W = 2 * DIM_W + 1;
   localparam int SUM_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;
   localparam int PAD_W  = CALC_W - DIM_W;
   localparam int CPAD_W = CALC_W - COORD_W;

   logic accept;

   // credit: items in the stages plus items in the queue
   logic [CRED_W-1:0] credit_ff, credit_in;

   // stage 1: captured request
   logic                      p1_valid_ff, p1_valid_in;
   cmd_type                   p1_cmd_ff;
   logic signed [COORD_W-1:0] p1_dx_ff, p1_dy_ff, p1_sx_ff, p1_sy_ff;
   logic        [COORD_W-1:0] p1_rw_ff, p1_rh_ff;
   logic        [PIXEL_W-1:0] p1_data_ff;
   logic                      p1_key_en_ff;

   logic signed [CALC_W-1:0] s1_ix, s1_iy, s1_rx, s1_ry, s1_rw, s1_rh;
   logic signed [CALC_W-1:0] s1_sw, s1_sh, s1_rw1, s1_rh1;
   logic signed [CALC_W-1:0] s1_ex, s1_ey, s1_cr, s1_cb;
   logic                     s1_empty;

   // stage 2: source-clamped rectangle
   logic                     p2_valid_ff, p2_valid_in;
   cmd_type                  p2_cmd_ff;
   logic       [PIXEL_W-1:0] p2_data_ff;
   logic                     p2_key_en_ff;
   logic signed [CALC_W-1:0] p2_ix_ff, p2_iy_ff, p2_rx_ff, p2_ry_ff;
   logic signed [CALC_W-1:0] p2_ex_ff, p2_ey_ff, p2_cr_ff, p2_cb_ff;
   logic                     p2_empty_ff;

   logic signed [CALC_W-1:0] s2_cl, s2_ct, s2_lft, s2_top, s2_rgt, s2_bot;
   logic signed [CALC_W-1:0] s2_wf, s2_hf, s2_ixf, s2_iyf;
   logic                     s2_empty;

   // stage 3: final rectangle
   logic                     p3_valid_ff, p3_valid_in;
   cmd_type                  p3_cmd_ff;
   logic       [PIXEL_W-1:0] p3_data_ff;
   logic                     p3_key_en_ff;
   logic                     p3_empty_ff;
   logic       [SPAN_W-1:0]  p3_span_ff, p3_rows_ff;
   logic       [DIM_W-1:0]   p3_ixf_ff, p3_iyf_ff;
   logic       [DIM_W:0]     p3_lft_ff, p3_top_ff;

   logic       [PROD_W-1:0]  s3_src_prod, s3_dst_prod;

   // stage 4: row products
   logic                     p4_valid_ff, p4_valid_in;
   cmd_type                  p4_cmd_ff;
   logic       [PIXEL_W-1:0] p4_data_ff;
   logic                     p4_key_en_ff;
   logic                     p4_empty_ff;
   logic       [SPAN_W-1:0]  p4_span_ff, p4_rows_ff;
   logic       [DIM_W-1:0]   p4_ixf_ff;
   logic       [DIM_W:0]     p4_lft_ff;
   logic       [PROD_W-1:0]  p4_src_prod_ff, p4_dst_prod_ff;

   logic       [SUM_W-1:0]   s4_src_sum, s4_dst_sum;

   // Stall the request side once every queue slot is spoken for
   assign req_stall = (credit_ff >= CRED_W'(Q_DEPTH));
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      case ({accept, q_pop})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   assign p1_valid_in = accept;
   assign p2_valid_in = p1_valid_ff;
   assign p3_valid_in = p2_valid_ff;
   assign p4_valid_in = p3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         p3_valid_ff <= p3_valid_in;
         p4_valid_ff <= p4_valid_in;
      end
   end

   // Capture the request; key and pixel share one data word
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_cmd_ff    <= cmd_type'(req_command);
         p1_dx_ff     <= req_dest_x;
         p1_dy_ff     <= req_dest_y;
         p1_sx_ff     <= req_src_offset_x;
         p1_sy_ff     <= req_src_offset_y;
         p1_rw_ff     <= req_rect_width;
         p1_rh_ff     <= req_rect_height;
         p1_data_ff   <= (req_command == CMD_PIXEL) ? req_pixel_in : req_key_color;
         p1_key_en_ff <= req_key_enable;
      end
   end

   // Clamp offsets at zero and the size to the source image
   always_comb begin
      s1_ix  = (p1_sx_ff < 0) ? '0 : CALC_W'(p1_sx_ff);
      s1_iy  = (p1_sy_ff < 0) ? '0 : CALC_W'(p1_sy_ff);
      s1_rx  = CALC_W'(p1_dx_ff);
      s1_ry  = CALC_W'(p1_dy_ff);
      s1_rw  = $signed({{CPAD_W{1'b0}}, p1_rw_ff});
      s1_rh  = $signed({{CPAD_W{1'b0}}, p1_rh_ff});
      s1_sw  = $signed({{PAD_W{1'b0}}, source_width});
      s1_sh  = $signed({{PAD_W{1'b0}}, source_height});
      s1_rw1 = (s1_ix + s1_rw > s1_sw) ? s1_sw - s1_ix : s1_rw;
      s1_rh1 = (s1_iy + s1_rh > s1_sh) ? s1_sh - s1_iy : s1_rh;
      s1_empty = (s1_rw1 <= 0) || (s1_rh1 <= 0);
      s1_ex  = s1_rx + s1_rw1;
      s1_ey  = s1_ry + s1_rh1;
      s1_cr  = $signed({{PAD_W{1'b0}}, clip_left}) + $signed({{PAD_W{1'b0}}, clip_width});
      s1_cb  = $signed({{PAD_W{1'b0}}, clip_top}) + $signed({{PAD_W{1'b0}}, clip_height});
   end

   always_ff @(posedge clock) begin
      p2_cmd_ff    <= p1_cmd_ff;
      p2_data_ff   <= p1_data_ff;
      p2_key_en_ff <= p1_key_en_ff;
      p2_ix_ff     <= s1_ix;
      p2_iy_ff     <= s1_iy;
      p2_rx_ff     <= s1_rx;
      p2_ry_ff     <= s1_ry;
      p2_ex_ff     <= s1_ex;
      p2_ey_ff     <= s1_ey;
      p2_cr_ff     <= s1_cr;
      p2_cb_ff     <= s1_cb;
      p2_empty_ff  <= s1_empty;
   end

   // Clip to the clip rectangle; near edges move in to the clip corner, far edges are cut at its right and bottom
   always_comb begin
      s2_cl  = $signed({{PAD_W{1'b0}}, clip_left});
      s2_ct  = $signed({{PAD_W{1'b0}}, clip_top});
      s2_lft = (p2_rx_ff < s2_cl) ? s2_cl : p2_rx_ff;
      s2_top = (p2_ry_ff < s2_ct) ? s2_ct : p2_ry_ff;
      s2_rgt = (p2_ex_ff > p2_cr_ff) ? p2_cr_ff : p2_ex_ff;
      s2_bot = (p2_ey_ff > p2_cb_ff) ? p2_cb_ff : p2_ey_ff;
      s2_wf  = s2_rgt - s2_lft;
      s2_hf  = s2_bot - s2_top;
      s2_ixf = p2_ix_ff + (s2_lft - p2_rx_ff);
      s2_iyf = p2_iy_ff + (s2_top - p2_ry_ff);
      s2_empty = p2_empty_ff || (p2_rx_ff > p2_cr_ff) || (p2_ry_ff > p2_cb_ff) ||
                 (p2_ex_ff < 0) || (p2_ey_ff < 0) || (s2_wf <= 0) || (s2_hf <= 0);
   end

   always_ff @(posedge clock) begin
      p3_cmd_ff    <= p2_cmd_ff;
      p3_data_ff   <= p2_data_ff;
      p3_key_en_ff <= p2_key_en_ff;
      p3_empty_ff  <= s2_empty;
      p3_span_ff   <= s2_wf[SPAN_W-1:0];
      p3_rows_ff   <= s2_hf[SPAN_W-1:0];
      p3_ixf_ff    <= s2_ixf[DIM_W-1:0];
      p3_iyf_ff    <= s2_iyf[DIM_W-1:0];
      p3_lft_ff    <= s2_lft[DIM_W:0];
      p3_top_ff    <= s2_top[DIM_W:0];
   end

   // Row offsets of source and target
   assign s3_src_prod = {{(DIM_W + 1){1'b0}}, p3_iyf_ff} * {{(DIM_W + 1){1'b0}}, source_width};
   assign s3_dst_prod = {{DIM_W{1'b0}}, p3_top_ff} * {{(DIM_W + 1){1'b0}}, target_width};

   always_ff @(posedge clock) begin
      p4_cmd_ff      <= p3_cmd_ff;
      p4_data_ff     <= p3_data_ff;
      p4_key_en_ff   <= p3_key_en_ff;
      p4_empty_ff    <= p3_empty_ff;
      p4_span_ff     <= p3_span_ff;
      p4_rows_ff     <= p3_rows_ff;
      p4_ixf_ff      <= p3_ixf_ff;
      p4_lft_ff      <= p3_lft_ff;
      p4_src_prod_ff <= s3_src_prod;
      p4_dst_prod_ff <= s3_dst_prod;
   end

   // Add the column and hand the item to the queue
   assign s4_src_sum = SUM_W'(p4_src_prod_ff) + SUM_W'(p4_ixf_ff);
   assign s4_dst_sum = SUM_W'(p4_dst_prod_ff) + SUM_W'(p4_lft_ff);

   assign push_valid          = p4_valid_ff;
   assign push_ctl.is_start   = (p4_cmd_ff == CMD_START);
   assign push_ctl.empty      = p4_empty_ff;
   assign push_ctl.key_enable = p4_key_en_ff;
   assign push_span           = p4_span_ff;
   assign push_rows           = p4_rows_ff;
   assign push_src_addr       = s4_src_sum[ADDR_BITS-1:0];
   assign push_dst_addr       = s4_dst_sum[ADDR_BITS-1:0];
   assign push_data           = p4_data_ff;

endmodule

@@ sv/ckb_back.sv @@
// Blitter back: walks the clipped region one pixel per transfer, applies the
// color key and holds the result register. Depends on ckb_pkg.
module ckb_back import ckb_pkg::*; #(
   parameter int MAX_DIM   = DEFAULT_MAX_DIM,
   parameter int ADDR_BITS = DEFAULT_ADDR_BITS,
   localparam int DIM_W    = $clog2(MAX_DIM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   // queue side
   input  logic                 q_valid,
   output logic                 q_pop,
   input  blit_ctl_type         q_ctl,
   input  logic [SPAN_W-1:0]    q_span,
   input  logic [SPAN_W-1:0]    q_rows,
   input  logic [ADDR_BITS-1:0] q_src_addr,
   input  logic [ADDR_BITS-1:0] q_dst_addr,
   input  logic [PIXEL_W-1:0]   q_data,
   // clamped strides
   input  logic [DIM_W-1:0]     source_width,
   input  logic [DIM_W-1:0]     target_width,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_empty_res,
   output logic [ADDR_BITS-1:0] rsp_next_src_addr,
   output logic [ADDR_BITS-1:0] rsp_dest_addr,
   output logic [PIXEL_W-1:0]   rsp_pixel_out,
   output logic                 rsp_write_enable,
   output logic                 rsp_last
);

   localparam int EXT_W = (ADDR_BITS > SPAN_W + 1) ? ADDR_BITS : SPAN_W + 1;

   // blit state
   logic                 active_ff, active_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [SPAN_W-1:0]    rows_ff, rows_in;
   logic [SPAN_W-1:0]    col_ff, col_in;
   logic [ADDR_BITS-1:0] src_ptr_ff, src_ptr_in;
   logic [ADDR_BITS-1:0] dst_ptr_ff, dst_ptr_in;
   logic [PIXEL_W-1:0]   key_ff, key_in;
   logic                 key_en_ff, key_en_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 r_empty;
   logic [ADDR_BITS-1:0] r_next_src;
   logic [ADDR_BITS-1:0] r_dest;
   logic [PIXEL_W-1:0]   r_pixel;
   logic                 r_we;
   logic                 r_last;
   logic                 rsp_empty_ff;
   logic [ADDR_BITS-1:0] rsp_next_src_ff;
   logic [ADDR_BITS-1:0] rsp_dest_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic                 rsp_we_ff;
   logic                 rsp_last_ff;

   // step helpers
   logic [EXT_W-1:0]     src_skip_ext, dst_skip_ext;
   logic [SPAN_W:0]      col_inc;
   logic                 row_end;
   logic [SPAN_W-1:0]    rows_dec;
   logic [ADDR_BITS-1:0] src_adv, dst_adv;
   logic                 keyed;

   // Take an item when the result register is free or being drained
   assign q_pop = q_valid & (~rsp_valid_ff | ~rsp_stall);

   // Jump from the end of one row to the start of the next, using the current strides
   assign src_skip_ext = EXT_W'(source_width) - EXT_W'(span_ff) + EXT_W'(1);
   assign dst_skip_ext = EXT_W'(target_width) - EXT_W'(span_ff) + EXT_W'(1);

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_end  = (col_inc >= {1'b0, span_ff});
   assign rows_dec = rows_ff - 1'b1;
   assign src_adv  = src_ptr_ff + (row_end ? src_skip_ext[ADDR_BITS-1:0] : ADDR_BITS'(1));
   assign dst_adv  = dst_ptr_ff + (row_end ? dst_skip_ext[ADDR_BITS-1:0] : ADDR_BITS'(1));
   assign keyed    = key_en_ff && (((q_data ^ key_ff) & KEY_MASK) == '0);

   always_comb begin
      active_in   = active_ff;
      span_in     = span_ff;
      rows_in     = rows_ff;
      col_in      = col_ff;
      src_ptr_in  = src_ptr_ff;
      dst_ptr_in  = dst_ptr_ff;
      key_in      = key_ff;
      key_en_in   = key_en_ff;
      r_empty     = 1'b0;
      r_next_src  = '0;
      r_dest      = '0;
      r_pixel     = '0;
      r_we        = 1'b0;
      r_last      = 1'b0;
      if (q_pop) begin
         if (q_ctl.is_start) begin
            // Load a new blit, dropping any running one
            key_in    = q_data;
            key_en_in = q_ctl.key_enable;
            col_in    = '0;
            r_empty   = q_ctl.empty;
            if (q_ctl.empty) begin
               active_in  = 1'b0;
               span_in    = '0;
               rows_in    = '0;
               src_ptr_in = '0;
               dst_ptr_in = '0;
            end else begin
               active_in   = 1'b1;
               span_in     = q_span;
               rows_in     = q_rows;
               src_ptr_in  = q_src_addr;
               dst_ptr_in  = q_dst_addr;
               r_next_src  = q_src_addr;
            end
         end else if (!active_ff || span_ff == '0 || rows_ff == '0) begin
            // Drop a pixel that arrives with no blit running
            active_in = 1'b0;
         end else begin
            // Emit one pixel and advance both pointers
            r_dest     = dst_ptr_ff;
            r_pixel    = (q_data & RGB_MASK) | ALPHA_OPAQUE;
            r_we       = ~keyed;
            src_ptr_in = src_adv;
            dst_ptr_in = dst_adv;
            col_in     = row_end ? '0 : col_inc[SPAN_W-1:0];
            if (row_end) begin
               rows_in = rows_dec;
            end
            if (row_end && rows_dec == '0) begin
               active_in = 1'b0;
               r_last    = 1'b1;
            end else begin
               r_next_src = src_adv;
            end
         end
      end
   end

   assign rsp_valid_in = q_pop | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold blit state and the result payload
   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      rows_ff     <= rows_in;
      col_ff      <= col_in;
      src_ptr_ff  <= src_ptr_in;
      dst_ptr_ff  <= dst_ptr_in;
      key_ff      <= key_in;
      key_en_ff   <= key_en_in;
      if (q_pop) begin
         rsp_empty_ff    <= r_empty;
         rsp_next_src_ff <= r_next_src;
         rsp_dest_ff     <= r_dest;
         rsp_pixel_ff    <= r_pixel;
         rsp_we_ff       <= r_we;
         rsp_last_ff     <= r_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_empty_res     = rsp_empty_ff;
   assign rsp_next_src_addr = rsp_next_src_ff;
   assign rsp_dest_addr     = rsp_dest_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of clipped_colorkey_blitter_top: a scoreboard class predicts
// every result transfer from the accepted requests and register writes.
// Depends on ckb_pkg and the block's top level.
module testbench import ckb_pkg::*;;

   localparam int ADDR_W        = DEFAULT_ADDR_BITS;
   localparam int DIM_MAX       = DEFAULT_MAX_DIM;
   localparam int NUM_CSR       = int'(CSR_TARGET_WIDTH) + 1;
   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct {
      cmd_type                   command;
      logic signed [COORD_W-1:0] dest_x;
      logic signed [COORD_W-1:0] dest_y;
      logic signed [COORD_W-1:0] src_offset_x;
      logic signed [COORD_W-1:0] src_offset_y;
      logic        [COORD_W-1:0] rect_width;
      logic        [COORD_W-1:0] rect_height;
      logic        [PIXEL_W-1:0] key_color;
      logic                      key_enable;
      logic        [PIXEL_W-1:0] pixel_in;
   } blit_request_type;

   typedef struct {
      logic               empty_res;
      logic [ADDR_W-1:0]  next_src_addr;
      logic [ADDR_W-1:0]  dest_addr;
      logic [PIXEL_W-1:0] pixel_out;
      logic               write_enable;
      logic               is_last;
   } blit_result_type;

   // Blit predictor and queue of awaited result transfers
   class blit_scoreboard;
      logic [CSR_DATA_W-1:0] regs [NUM_CSR];
      bit                    active;
      logic [SPAN_W-1:0]     span_width;
      logic [SPAN_W-1:0]     rows_left;
      int                    column_count;
      logic [ADDR_W-1:0]     src_ptr;
      logic [ADDR_W-1:0]     dst_ptr;
      logic [PIXEL_W-1:0]    saved_key;
      bit                    saved_key_en;
      blit_result_type       awaited_rsp [$];
      int                    failures;

      function new();
         regs[CSR_CLIP_LEFT]     = RST_CLIP_LEFT;
         regs[CSR_CLIP_TOP]      = RST_CLIP_TOP;
         regs[CSR_CLIP_WIDTH]    = RST_CLIP_WIDTH;
         regs[CSR_CLIP_HEIGHT]   = RST_CLIP_HEIGHT;
         regs[CSR_SOURCE_WIDTH]  = RST_SOURCE_WIDTH;
         regs[CSR_SOURCE_HEIGHT] = RST_SOURCE_HEIGHT;
         regs[CSR_TARGET_WIDTH]  = RST_TARGET_WIDTH;
         active       = 1'b0;
         span_width   = '0;
         rows_left    = '0;
         column_count = 0;
         src_ptr      = '0;
         dst_ptr      = '0;
         saved_key    = '0;
         saved_key_en = 1'b0;
         failures     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         regs[idx] = value;
      endfunction

      // Register value as a dimension; anything above the maximum counts as the maximum
      function int dim(csr_index_type idx);
         return (int'(regs[idx]) > DIM_MAX) ? DIM_MAX : int'(regs[idx]);
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      // Advance the blit state by one accepted request and queue its result
      function void note_request(blit_request_type r);
         blit_result_type res;
         longint          cl, ct, cr, cb, sw, sh, tw, rx, ry, ix, iy, rw, rh;
         bit              is_empty, keyed;
         res = '{default: 0};
         if (r.command == CMD_START) begin
            cl = dim(CSR_CLIP_LEFT);
            ct = dim(CSR_CLIP_TOP);
            cr = cl + dim(CSR_CLIP_WIDTH);
            cb = ct + dim(CSR_CLIP_HEIGHT);
            sw = dim(CSR_SOURCE_WIDTH);
            sh = dim(CSR_SOURCE_HEIGHT);
            tw = dim(CSR_TARGET_WIDTH);
            rx = longint'(r.dest_x);
            ry = longint'(r.dest_y);
            ix = longint'(r.src_offset_x);
            iy = longint'(r.src_offset_y);
            rw = longint'(r.rect_width);
            rh = longint'(r.rect_height);
            // clamp to the source image
            if (ix < 0) ix = 0;
            if (iy < 0) iy = 0;
            if (ix + rw > sw) rw = sw - ix;
            if (iy + rh > sh) rh = sh - iy;
            is_empty = (rw <= 0 || rh <= 0 || rx > cr || ry > cb || rx + rw < 0 ||
                        ry + rh < 0);
            // clamp to the clip rectangle
            if (!is_empty) begin
               if (rx < cl) begin
                  rw -= cl - rx;
                  ix += cl - rx;
                  rx = cl;
               end
               if (ry < ct) begin
                  rh -= ct - ry;
                  iy += ct - ry;
                  ry = ct;
               end
               if (rx + rw > cr) rw = cr - rx;
               if (ry + rh > cb) rh = cb - ry;
               if (rw <= 0 || rh <= 0) is_empty = 1'b1;
            end
            saved_key    = r.key_color;
            saved_key_en = r.key_enable;
            column_count = 0;
            if (is_empty) begin
               active        = 1'b0;
               span_width    = '0;
               rows_left     = '0;
               src_ptr       = '0;
               dst_ptr       = '0;
               res.empty_res = 1'b1;
            end else begin
               active            = 1'b1;
               span_width        = rw[SPAN_W-1:0];
               rows_left         = rh[SPAN_W-1:0];
               src_ptr           = ADDR_W'(iy * sw + ix);
               dst_ptr           = ADDR_W'(ry * tw + rx);
               res.next_src_addr = src_ptr;
            end
         end else if (!active || span_width == '0 || rows_left == '0) begin
            // drop a pixel that arrives with no blit running
            active = 1'b0;
         end else begin
            keyed = saved_key_en && (((r.pixel_in ^ saved_key) & KEY_MASK) == '0);
            res.dest_addr    = dst_ptr;
            res.pixel_out    = ALPHA_OPAQUE | (r.pixel_in & RGB_MASK);
            res.write_enable = !keyed;
            src_ptr++;
            dst_ptr++;
            column_count++;
            // wrap to the start of the next row
            if (column_count >= int'(span_width)) begin
               column_count = 0;
               rows_left--;
               src_ptr = src_ptr + ADDR_W'(dim(CSR_SOURCE_WIDTH)) - ADDR_W'(span_width);
               dst_ptr = dst_ptr + ADDR_W'(dim(CSR_TARGET_WIDTH)) - ADDR_W'(span_width);
               if (rows_left == '0) begin
                  active      = 1'b0;
                  res.is_last = 1'b1;
               end
            end
            res.next_src_addr = active ? src_ptr : '0;
         end
         awaited_rsp.push_back(res);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
            failures++;
         end
      endfunction

      // Compare one result transfer with the oldest awaited result
      function void check_result(blit_result_type got);
         blit_result_type want;
         if (awaited_rsp.size() == 0) begin
            $error("result transfer with no request awaiting it");
            failures++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("empty_res", want.empty_res, got.empty_res);
         compare_field("next_src_addr", want.next_src_addr, got.next_src_addr);
         compare_field("dest_addr", want.dest_addr, got.dest_addr);
         compare_field("pixel_out", want.pixel_out, got.pixel_out);
         compare_field("write_enable", want.write_enable, got.write_enable);
         compare_field("last", want.is_last, got.is_last);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_START;
   logic signed [COORD_W-1:0] req_dest_x = '0;
   logic signed [COORD_W-1:0] req_dest_y = '0;
   logic signed [COORD_W-1:0] req_src_offset_x = '0;
   logic signed [COORD_W-1:0] req_src_offset_y = '0;
   logic        [COORD_W-1:0] req_rect_width = '0;
   logic        [COORD_W-1:0] req_rect_height = '0;
   logic        [PIXEL_W-1:0] req_key_color = '0;
   logic                      req_key_enable = 1'b0;
   logic        [PIXEL_W-1:0] req_pixel_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_empty_res;
   logic         [ADDR_W-1:0] rsp_next_src_addr;
   logic         [ADDR_W-1:0] rsp_dest_addr;
   logic        [PIXEL_W-1:0] rsp_pixel_out;
   logic                      rsp_write_enable;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic    [CSR_INDEX_W-1:0] csr_index = '0;
   logic     [CSR_DATA_W-1:0] csr_data = '0;

   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   bit             rsp_hold = 1'b0;
   blit_scoreboard sb;

   clipped_colorkey_blitter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_dest_x        (req_dest_x),
      .req_dest_y        (req_dest_y),
      .req_src_offset_x  (req_src_offset_x),
      .req_src_offset_y  (req_src_offset_y),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_key_color     (req_key_color),
      .req_key_enable    (req_key_enable),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_empty_res     (rsp_empty_res),
      .rsp_next_src_addr (rsp_next_src_addr),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Stall the result channel at random, or throughout a hold-off
   always @(negedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(blit_result_type'{rsp_empty_res, rsp_next_src_addr, rsp_dest_addr,
                                           rsp_pixel_out, rsp_write_enable, rsp_last});
   end

   initial begin
      #TIMEOUT_NS;
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one request after a random gap and hold it until its transfer
   task automatic send_request(blit_request_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= r.command;
      req_dest_x       <= r.dest_x;
      req_dest_y       <= r.dest_y;
      req_src_offset_x <= r.src_offset_x;
      req_src_offset_y <= r.src_offset_y;
      req_rect_width   <= r.rect_width;
      req_rect_height  <= r.rect_height;
      req_key_color    <= r.key_color;
      req_key_enable   <= r.key_enable;
      req_pixel_in     <= r.pixel_in;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_start(input logic signed [COORD_W-1:0] dx, dy, ox, oy,
                             input logic [COORD_W-1:0] w, h,
                             input logic [PIXEL_W-1:0] key, input logic key_en);
      blit_request_type r;
      r = '{CMD_START, dx, dy, ox, oy, w, h, key, key_en, $urandom()};
      send_request(r);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      blit_request_type r;
      r = '{CMD_PIXEL, COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
            COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()), $urandom(),
            1'($urandom_range(0, 1)), pix};
      send_request(r);
   endtask

   // Hold the sender until every awaited result has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] l, t, w, h, sw, sh, tw);
      logic [CSR_DATA_W-1:0] vals [NUM_CSR];
      vals[CSR_CLIP_LEFT]     = l;
      vals[CSR_CLIP_TOP]      = t;
      vals[CSR_CLIP_WIDTH]    = w;
      vals[CSR_CLIP_HEIGHT]   = h;
      vals[CSR_SOURCE_WIDTH]  = sw;
      vals[CSR_SOURCE_HEIGHT] = sh;
      vals[CSR_TARGET_WIDTH]  = tw;
      for (int i = 0; i < NUM_CSR; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(csr_index_type'(i), vals[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Close any running blit, drain, and let the block settle before new settings
   task automatic end_phase();
      if (sb.active) send_start('0, '0, '0, '0, '0, '0, $urandom(), 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed blits near the clip rectangle, some noise starts,
   // truncated pixel runs and stray pixels
   task automatic run_random(int count, bit pause_midway);
      int                 done, n, k, dx, dy, ox, oy;
      bit                 paused;
      logic [PIXEL_W-1:0] key, pix;
      done   = 0;
      paused = 1'b0;
      while (done < count) begin
         if (pause_midway && !paused && done >= count / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         key = $urandom();
         if ($urandom_range(0, 99) < 20) begin
            send_start(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                       COORD_W'($urandom()),
                       $urandom_range(0, 1) ? COORD_W'($urandom())
                                            : COORD_W'($urandom_range(0, 12)),
                       $urandom_range(0, 1) ? COORD_W'($urandom())
                                            : COORD_W'($urandom_range(0, 12)),
                       key, 1'($urandom_range(0, 1)));
         end else begin
            dx = sb.dim(CSR_CLIP_LEFT) + int'($urandom_range(0, sb.dim(CSR_CLIP_WIDTH) + 6)) - 4;
            dy = sb.dim(CSR_CLIP_TOP) + int'($urandom_range(0, sb.dim(CSR_CLIP_HEIGHT) + 6)) - 4;
            ox = int'($urandom_range(0, sb.dim(CSR_SOURCE_WIDTH) + 4)) - 3;
            oy = int'($urandom_range(0, sb.dim(CSR_SOURCE_HEIGHT) + 4)) - 3;
            send_start(COORD_W'(dx), COORD_W'(dy), COORD_W'(ox), COORD_W'(oy),
                       COORD_W'($urandom_range(0, 9)), COORD_W'($urandom_range(0, 6)),
                       key, $urandom_range(0, 99) < 60);
         end
         done++;
         // choose a full, truncated or overlong pixel run
         n = sb.active ? int'(sb.span_width) * int'(sb.rows_left) : 0;
         if (n == 0)
            k = $urandom_range(0, 1);
         else if (n <= 120 && $urandom_range(0, 99) < 80)
            k = n + (($urandom_range(0, 99) < 10) ? 1 : 0);
         else
            k = $urandom_range(0, (n > 40) ? 40 : n - 1);
         repeat (k) begin
            pix = $urandom();
            if ($urandom_range(0, 99) < 30) pix = (pix & ~KEY_MASK) | (key & KEY_MASK);
            if (sb.active) done++;
            send_pixel(pix);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Stray pixel and a start against the reset registers (empty source)
      send_pixel(32'hDEAD_BEEF);
      send_start(16'sd10, 16'sd10, '0, '0, 16'd4, 16'd4, '0, 1'b0);
      wait_drained();

      write_config(12'd0, 12'd0, 12'd640, 12'd480, 12'd24, 12'd16, 12'd640);
      // Keyed 3x2 blit: keyed and unkeyed pixels, extremes of the pixel value
      send_start(16'sd2, 16'sd3, 16'sd1, 16'sd1, 16'd3, 16'd2, KEY_MASK, 1'b1);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0010_1010);
      send_pixel(32'h1234_5678);
      send_pixel(32'hFF10_1010);
      send_pixel(32'hABCD_EF01);
      send_pixel(32'h5555_AAAA);
      // Zero width, then a maximal request clamped to the source and dropped early
      send_start('0, '0, '0, '0, 16'd0, 16'd5, '0, 1'b0);
      send_start('0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      // Start while busy: negative destination and offset clamped
      send_start(-16'sd2, -16'sd1, -16'sd32768, -16'sd7, 16'd4, 16'd3, '0, 1'b0);
      repeat (4) send_pixel($urandom());
      // Regions that end up empty
      send_start(16'sd32767, 16'sd32767, '0, '0, 16'd4, 16'd4, '0, 1'b0);
      send_start('0, '0, 16'sd32767, '0, 16'd4, 16'd4, '0, 1'b0);
      send_start(-16'sd32768, -16'sd32768, '0, '0, 16'hFFFF, 16'hFFFF, '0, 1'b0);
      // Clipped at the right and bottom edges
      send_start(16'sd638, 16'sd478, '0, '0, 16'd5, 16'd5, '0, 1'b1);
      repeat (4) send_pixel($urandom());
      run_random(150, 1'b0);
      end_phase();

      // Tight clip rectangle, sender idling
      send_idle_pct = 79;
      write_config(12'd5, 12'd4, 12'd12, 12'd9, 12'd30, 12'd20, 12'd40);
      run_random(200, 1'b0);
      end_phase();

      // Target stride below the span; receiver stalling and one long hold-off
      send_idle_pct = 0;
      rsp_stall_pct = 79;
      write_config(12'd0, 12'd0, 12'd4095, 12'd2048, 12'd10, 12'd8, 12'd3);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      run_random(150, 1'b0);
      end_phase();

      // All registers at their maximum; addresses wrap
      send_idle_pct = 27;
      rsp_stall_pct = 27;
      write_config(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      run_random(150, 1'b0);
      end_phase();

      // All registers zero
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_config('0, '0, '0, '0, '0, '0, '0);
      run_random(60, 1'b0);
      end_phase();

      // Random small settings; the sender pauses once for a full drain
      send_idle_pct = 27;
      rsp_stall_pct = 27;
      write_config(12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
                   12'($urandom_range(0, 48)), 12'($urandom_range(0, 48)),
                   12'($urandom_range(1, 48)), 12'($urandom_range(1, 48)),
                   12'($urandom_range(0, 64)));
      run_random(240, 1'b1);
      end_phase();

      // Random settings over the full register range
      send_idle_pct = 79;
      rsp_stall_pct = 0;
      write_config(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                   12'($urandom()), 12'($urandom()), 12'($urandom()));
      run_random(100, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ clipped_colorkey_blitter_top.f @@
sv/ckb_pkg.sv
sv/ckb_queue.sv
sv/ckb_front.sv
sv/ckb_back.sv
sv/clipped_colorkey_blitter_top.sv
dv/testbench.sv
